@@ sv/lbps_pkg.sv @@
// lbps_pkg: shared types, widths and codes for the leaky bucket packet shaper
// no dependencies; imported by every module of the shaper
package lbps_pkg;

    // packet store, depth must be a power of two
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // field widths
    localparam int ID_W     = 16;
    localparam int SIZE_W   = 16;
    localparam int RATE_W   = 20;
    localparam int BYTES_W  = 21;
    localparam int IN_DATA_W  = ID_W + SIZE_W;
    localparam int OUT_DATA_W = ID_W;

    // command queue between front and back, depth a power of two
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    // configuration registers
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = CFG_IDX_W'(1);
    localparam logic [RATE_W-1:0] LEAK_RATE_RST  = RATE_W'(1000);
    localparam logic [RATE_W-1:0] BYTE_LIMIT_RST = RATE_W'(10000);

    typedef enum logic {
        MODE_ARRIVAL = 1'b0,
        MODE_TICK    = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        EV_ACCEPT = 2'd0,
        EV_REJECT = 2'd1,
        EV_SENT   = 2'd2,
        EV_EMPTY  = 2'd3
    } t_event;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } t_back_state;

    // one classified input item
    typedef struct packed {
        t_mode             kind;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } t_cmd;

    // one packet store entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // one result item
    typedef struct packed {
        t_event          ev;
        logic [ID_W-1:0] id;
        logic            last;
    } t_result;

    // occupancy seen from outside the back end
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [BYTES_W-1:0] bytes;
    } t_back_status;

endpackage

@@ sv/lbps_front.sv @@
// lbps_front: accepts input transactions, classifies them and queues commands
// depends on lbps_pkg
module lbps_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lbps_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_in_kind,
    output logic                              o_cmd_valid,
    output lbps_pkg::t_cmd                    o_cmd,
    input  logic                              i_cmd_pop
);
    import lbps_pkg::*;

    t_cmd                  r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                  w_push;
    logic                  w_pop;
    t_cmd                  w_cmd;

    // classify the incoming item
    always_comb begin
        w_cmd.kind = t_mode'(i_in_kind);
        w_cmd.id   = i_in_data[ID_W-1:0];
        w_cmd.size = i_in_data[IN_DATA_W-1:ID_W];
    end

    assign o_in_ready  = (r_cnt != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    // queue pointers
    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + CMDQ_CNT_W'(w_push) - CMDQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

@@ sv/lbps_back.sv @@
// lbps_back: packet store, byte accounting and the tick drain sequencer
// depends on lbps_pkg
module lbps_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  lbps_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    input  logic [lbps_pkg::RATE_W-1:0]    i_leak_rate,
    input  logic [lbps_pkg::RATE_W-1:0]    i_byte_limit,
    input  logic                           i_res_ready,
    output logic                           o_res_push,
    output lbps_pkg::t_result              o_res,
    output lbps_pkg::t_back_status         o_status
);
    import lbps_pkg::*;

    t_back_state        r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [RATE_W-1:0]  r_budget, n_budget;
    logic               r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]    r_pend_id, n_pend_id;
    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd;

    logic [PTR_W-1:0]   w_tail;
    logic [BYTES_W:0]   w_total;
    logic               w_reject;
    logic               w_empty;
    logic               w_is_arr;
    logic               w_is_tick;
    logic               w_fits;
    logic               w_wr_en;
    t_entry             w_wr_data;

    // arrival check and drain fit check
    assign w_tail    = r_head + r_count[PTR_W-1:0];
    assign w_total   = {1'b0, r_bytes} + (BYTES_W + 1)'(i_cmd.size);
    assign w_empty   = (r_count == '0);
    assign w_reject  = (w_total > (BYTES_W + 1)'(i_byte_limit))
                    || (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_is_arr  = i_cmd_valid && (i_cmd.kind == MODE_ARRIVAL);
    assign w_is_tick = i_cmd_valid && (i_cmd.kind == MODE_TICK);
    assign w_fits    = !w_empty && (RATE_W'(r_rd.size) <= r_budget);
    assign w_wr_en   = (r_state == ST_IDLE) && w_is_arr && i_res_ready && !w_reject;
    assign w_wr_data = '{id: i_cmd.id, size: i_cmd.size};

    assign o_status = '{count: r_count, bytes: r_bytes};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_is_tick && !w_empty) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_fits && (!r_pend_vld || i_res_ready)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{ev: EV_ACCEPT, id: i_cmd.id, last: 1'b1};
        n_head     = r_head;
        n_count    = r_count;
        n_bytes    = r_bytes;
        n_budget   = r_budget;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        unique case (r_state)
            ST_IDLE: begin
                if (w_is_arr && i_res_ready) begin
                    o_cmd_pop  = 1'b1;
                    o_res_push = 1'b1;
                    if (w_reject) begin
                        o_res.ev = EV_REJECT;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_bytes = w_total[BYTES_W-1:0];
                    end
                end else if (w_is_tick && w_empty && i_res_ready) begin
                    o_cmd_pop  = 1'b1;
                    o_res_push = 1'b1;
                    o_res      = '{ev: EV_EMPTY, id: '0, last: 1'b1};
                end else if (w_is_tick && !w_empty) begin
                    o_cmd_pop  = 1'b1;
                    n_budget   = i_leak_rate;
                    n_pend_vld = 1'b0;
                end
            end
            ST_DRAIN: begin
                // a sent packet is held until the next head shows whether it is the last
                o_res = '{ev: EV_SENT, id: r_pend_id, last: !w_fits};
                if (w_fits) begin
                    if (!r_pend_vld || i_res_ready) begin
                        o_res_push = r_pend_vld;
                        n_pend_vld = 1'b1;
                        n_pend_id  = r_rd.id;
                        n_head     = r_head + 1'b1;
                        n_count    = r_count - 1'b1;
                        n_budget   = r_budget - RATE_W'(r_rd.size);
                        n_bytes    = r_bytes - BYTES_W'(r_rd.size);
                    end
                end else if (r_pend_vld && i_res_ready) begin
                    o_res_push = 1'b1;
                    n_pend_vld = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_bytes    <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_bytes    <= n_bytes;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_budget  <= n_budget;
        r_pend_id <= n_pend_id;
    end

    // packet store, write at tail, registered read of the next head
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_tail] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && (w_tail == n_head)) begin
            r_rd <= w_wr_data;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

endmodule

@@ sv/lbps_out.sv @@
// lbps_out: output register stage that drives the result stream
// depends on lbps_pkg
module lbps_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_res_push,
    input  lbps_pkg::t_result                 i_res,
    output logic                              o_res_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lbps_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [1:0]                        o_out_kind,
    output logic                              o_out_last
);
    import lbps_pkg::*;

    logic    r_valid;
    t_result r_res;

    // stage is free when empty or being drained this cycle
    assign o_res_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_push) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_res.id;
    assign o_out_kind  = r_res.ev;
    assign o_out_last  = r_res.last;

endmodule

@@ sv/leaky_bucket_packet_shaper.sv @@
// leaky_bucket_packet_shaper: top level with configuration registers and checks
// depends on lbps_pkg, lbps_front, lbps_back, lbps_out
//
// Leaky bucket shaper. An arrival (tuser 0) is queued if its size keeps the
// queued byte total within byte_limit and one of the 32 store entries is free,
// and gives one accepted or rejected result. A tick (tuser 1) sets the budget
// to leak_rate and sends packets from the head in order while each fits; each
// sent packet gives one result, tlast on the final one. A tick on an empty
// store gives one empty result, a tick whose head does not fit gives none.
// A tick that sends packets loads the budget and starts the drain, sends each
// packet that fits in order, then finds the head that stops it (or the empty
// store) and releases the last result; a tick whose head does not fit only
// loads the budget and finds that head. A two entry command queue lets the
// input take items while a drain runs. The user must write configuration
// through the cfg port only while the block is idle; the block itself does
// not enforce this. Unknown indexes are ignored.
module leaky_bucket_packet_shaper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lbps_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // packet_id, packet_size
    input  logic                               s_axis_tuser,  // mode
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lbps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // result_id
    output logic [1:0]                         m_axis_tuser,  // event_res
    output logic                               m_axis_tlast,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbps_pkg::RATE_W-1:0]        i_cfg_data
);
    import lbps_pkg::*;

    logic [RATE_W-1:0] r_leak_rate;
    logic [RATE_W-1:0] r_byte_limit;
    logic              w_cmd_valid;
    t_cmd              w_cmd;
    logic              w_cmd_pop;
    logic              w_res_ready;
    logic              w_res_push;
    t_result           w_res;
    t_back_status      w_status;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak_rate  <= LEAK_RATE_RST;
            r_byte_limit <= BYTE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_LEAK_RATE) begin
                r_leak_rate <= i_cfg_data;
            end
            if (i_cfg_index == CFG_BYTE_LIMIT) begin
                r_byte_limit <= i_cfg_data;
            end
        end
    end

    lbps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    lbps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .i_leak_rate  (r_leak_rate),
        .i_byte_limit (r_byte_limit),
        .i_res_ready  (w_res_ready),
        .o_res_push   (w_res_push),
        .o_res        (w_res),
        .o_status     (w_status)
    );

    lbps_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_push  (w_res_push),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // store occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= CNT_W'(QUEUE_DEPTH))
        else $error("packet store count over depth");

    // an empty store holds no bytes
    a_bytes_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.count == '0) |-> (w_status.bytes == '0))
        else $error("queued bytes nonzero with empty store");

    // the back end only hands over a result when the output stage can take it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> w_res_ready)
        else $error("result pushed into a full output stage");

    // a popped command always comes from a non-empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from an empty queue");

endmodule

@@ bench/leaky_bucket_packet_shaper_tb.sv @@
`timescale 1ns / 1ps
// leaky_bucket_packet_shaper_tb: self-checking bench for the leaky bucket packet shaper
// depends on lbps_pkg and leaky_bucket_packet_shaper; holds its own shaper predictor
module leaky_bucket_packet_shaper_tb;
    import lbps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_MAX   = 32;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = '1;
    localparam logic [RATE_W-1:0]    RATE_MAX        = '1;

    typedef struct {
        logic [ID_W-1:0]   pkt_id;
        logic [SIZE_W-1:0] pkt_bytes;
    } t_held_packet;

    typedef struct {
        t_event          ev;
        logic [ID_W-1:0] id;
        logic            last;
    } t_shaper_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // packet_id, packet_size
    logic                  s_axis_tuser = 1'b0; // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // result_id
    logic [1:0]            m_axis_tuser;        // event_res
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [RATE_W-1:0]     i_cfg_data = '0;

    // predictor state: register copies, packet store, queued byte total
    logic [RATE_W-1:0]  leak_rate_cfg  = LEAK_RATE_RST;
    logic [RATE_W-1:0]  byte_limit_cfg = BYTE_LIMIT_RST;
    logic [BYTES_W-1:0] held_bytes     = '0;
    t_held_packet       held_packets[$];
    t_shaper_result     pending_results[$];
    t_shaper_result     oldest_result;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_req_len  = 0;
    int hold_req_seq  = 0;
    int hold_seen_seq = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int mismatch_count = 0;

    leaky_bucket_packet_shaper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // shaper predictor: queue or reject arrivals, drain the head on ticks
    function automatic void predict_shaper(input t_mode kind, input logic [ID_W-1:0] id,
                                           input logic [SIZE_W-1:0] bytes);
        logic [BYTES_W-1:0] total;
        logic [BYTES_W-1:0] budget;
        int sent;
        total = held_bytes + bytes;
        if (kind == MODE_ARRIVAL) begin
            if (total > byte_limit_cfg || held_packets.size() >= QUEUE_DEPTH) begin
                pending_results.push_back('{ev: EV_REJECT, id: id, last: 1'b1});
            end else begin
                held_packets.push_back('{pkt_id: id, pkt_bytes: bytes});
                held_bytes = total;
                pending_results.push_back('{ev: EV_ACCEPT, id: id, last: 1'b1});
            end
        end else if (held_packets.size() == 0) begin
            pending_results.push_back('{ev: EV_EMPTY, id: '0, last: 1'b1});
        end else begin
            budget = leak_rate_cfg;
            sent = 0;
            while (held_packets.size() > 0 && sent < DRAIN_MAX
                   && held_packets[0].pkt_bytes <= budget) begin
                budget     -= held_packets[0].pkt_bytes;
                held_bytes -= held_packets[0].pkt_bytes;
                pending_results.push_back('{ev: EV_SENT, id: held_packets[0].pkt_id,
                                            last: 1'b0});
                void'(held_packets.pop_front());
                sent++;
            end
            // head that does not fit gives no result at all
            if (sent > 0)
                pending_results[$].last = 1'b1;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: ev %0d id %h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_axis_tuser !== oldest_result.ev)
                    report_mismatch($sformatf("event_res %0d, want %0d (id %h)",
                                              m_axis_tuser, oldest_result.ev,
                                              oldest_result.id));
                if (m_axis_tdata !== oldest_result.id)
                    report_mismatch($sformatf("result_id %h, want %h",
                                              m_axis_tdata, oldest_result.id));
                if (m_axis_tlast !== oldest_result.last)
                    report_mismatch($sformatf("last %b, want %b (id %h)",
                                              m_axis_tlast, oldest_result.last,
                                              oldest_result.id));
            end
        end
    end

    // result side ready: random stalls, or a long hold when requested
    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen_seq) begin
            hold_seen_seq <= hold_req_seq;
            hold_left     <= hold_req_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // offer one input transaction and update the predictor once it is taken
    task automatic send_item(input t_mode kind, input logic [ID_W-1:0] id,
                             input logic [SIZE_W-1:0] bytes);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {bytes, id};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_shaper(kind, id, bytes);
        items_sent++;
    endtask

    // drop valid, wait for every pending result, then let silent ticks finish
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LEAK_RATE)
            leak_rate_cfg = val;
        else if (idx == CFG_BYTE_LIMIT)
            byte_limit_cfg = val;
        reg_writes++;
    endtask

    // reset values: empty tick, zero-size and exact-budget drain
    task automatic test_reset_defaults();
        send_item(MODE_TICK, 16'h1234, 16'h5678);
        send_item(MODE_ARRIVAL, 16'h0000, 16'd0);
        send_item(MODE_ARRIVAL, 16'hFFFF, 16'd1000);
        send_item(MODE_TICK, 16'hFFFF, 16'hFFFF);
        send_item(MODE_TICK, 16'h0000, 16'h0000);
    endtask

    // byte limit edges and a head too large for the budget
    task automatic test_byte_limit();
        send_item(MODE_ARRIVAL, 16'hA001, 16'hFFFF);
        send_item(MODE_ARRIVAL, 16'hA002, 16'd9000);
        send_item(MODE_ARRIVAL, 16'hA003, 16'd1001);
        send_item(MODE_ARRIVAL, 16'hA004, 16'd1000);
        send_item(MODE_TICK, 16'h0, 16'h0);
        write_reg(CFG_LEAK_RATE, RATE_MAX);
        send_item(MODE_TICK, 16'h0, 16'h0);
    endtask

    // limit lowered under the queued total keeps the packets
    task automatic test_limit_lowered();
        send_item(MODE_ARRIVAL, 16'hB001, 16'd5000);
        send_item(MODE_ARRIVAL, 16'hB002, 16'd5000);
        write_reg(CFG_BYTE_LIMIT, '0);
        send_item(MODE_ARRIVAL, 16'hB003, 16'd0);
        send_item(MODE_TICK, 16'h0, 16'h0);
        send_item(MODE_ARRIVAL, 16'hB004, 16'd0);
        send_item(MODE_ARRIVAL, 16'hB005, 16'd1);
        send_item(MODE_TICK, 16'h0, 16'h0);
    endtask

    // zero leak rate only lets zero-size packets through
    task automatic test_zero_leak();
        write_reg(CFG_LEAK_RATE, '0);
        write_reg(CFG_BYTE_LIMIT, RATE_MAX);
        send_item(MODE_ARRIVAL, 16'hC001, 16'd0);
        send_item(MODE_ARRIVAL, 16'hC002, 16'd1);
        send_item(MODE_ARRIVAL, 16'hC003, 16'd0);
        send_item(MODE_TICK, 16'h0, 16'h0);
        send_item(MODE_TICK, 16'h0, 16'h0);
        write_reg(CFG_LEAK_RATE, RATE_W'(1));
        send_item(MODE_TICK, 16'h0, 16'h0);
    endtask

    // writes to unused indexes must not touch either register
    task automatic test_unknown_index();
        write_reg(CFG_UNUSED_LOW, '0);
        write_reg(CFG_UNUSED_HIGH, RATE_MAX);
        send_item(MODE_ARRIVAL, 16'hD001, 16'd2);
        send_item(MODE_TICK, 16'h0, 16'h0);
        write_reg(CFG_LEAK_RATE, RATE_MAX);
        send_item(MODE_TICK, 16'h0, 16'h0);
    endtask

    // fill every store entry, reject one more, drain all in one tick
    task automatic test_full_queue();
        write_reg(CFG_LEAK_RATE, '0);
        for (int k = 0; k < QUEUE_DEPTH; k++)
            send_item(MODE_ARRIVAL, ID_W'($urandom), SIZE_W'($urandom_range(0, 2000)));
        send_item(MODE_ARRIVAL, ID_W'($urandom), 16'd0);
        write_reg(CFG_LEAK_RATE, RATE_MAX);
        send_item(MODE_TICK, 16'h0, 16'h0);
        send_item(MODE_TICK, 16'h0, 16'h0);
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_backpressure();
        hold_req_len <= 400;
        hold_req_seq <= hold_req_seq + 1;
        for (int k = 0; k < 40; k++)
            send_item(($urandom_range(3) == 0) ? MODE_TICK : MODE_ARRIVAL,
                      ID_W'($urandom), SIZE_W'($urandom_range(0, 3000)));
        wait_quiet();
    endtask

    // random traffic under one register setting and one idling mix
    task automatic test_random_traffic(input int setting, input int tx_idle, input int rx_stall);
        int cap;
        int pick;
        logic [SIZE_W-1:0] bytes;
        case (setting)
            0: begin write_reg(CFG_LEAK_RATE, LEAK_RATE_RST);
                     write_reg(CFG_BYTE_LIMIT, BYTE_LIMIT_RST); end
            1: begin write_reg(CFG_LEAK_RATE, RATE_MAX);
                     write_reg(CFG_BYTE_LIMIT, RATE_MAX); end
            2: begin write_reg(CFG_LEAK_RATE, '0);
                     write_reg(CFG_BYTE_LIMIT, RATE_MAX); end
            3: begin write_reg(CFG_LEAK_RATE, RATE_W'($urandom_range(0, 4000)));
                     write_reg(CFG_BYTE_LIMIT, RATE_W'($urandom_range(0, 100000))); end
            4: begin write_reg(CFG_LEAK_RATE, RATE_W'($urandom_range(1, 70000)));
                     write_reg(CFG_BYTE_LIMIT, RATE_MAX); end
            5: begin write_reg(CFG_LEAK_RATE, RATE_W'(500));
                     write_reg(CFG_BYTE_LIMIT, '0); end
            6: begin write_reg(CFG_LEAK_RATE, RATE_W'($urandom));
                     write_reg(CFG_BYTE_LIMIT, RATE_W'($urandom_range(0, 65535))); end
            default: begin write_reg(CFG_LEAK_RATE, RATE_MAX);
                     write_reg(CFG_BYTE_LIMIT, RATE_W'($urandom)); end
        endcase
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        // sizes mostly a fraction of the budget so that ticks send several packets
        cap = leak_rate_cfg / 3;
        if (cap < 16)
            cap = 16;
        if (cap > 65535)
            cap = 65535;
        for (int k = 0; k < 32; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                bytes = '0;
            else if (pick == 1)
                bytes = SIZE_W'($urandom);
            else
                bytes = SIZE_W'($urandom_range(0, cap));
            send_item(($urandom_range(3) == 0) ? MODE_TICK : MODE_ARRIVAL,
                      ID_W'($urandom), bytes);
        end
        wait_quiet();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_byte_limit();
        test_limit_lowered();
        test_zero_leak();
        test_unknown_index();
        test_full_queue();
        test_backpressure();
        test_random_traffic(0, 0, 0);
        test_random_traffic(1, 0, 0);
        test_random_traffic(2, 61, 0);
        test_random_traffic(3, 61, 0);
        test_random_traffic(4, 0, 61);
        test_random_traffic(5, 0, 61);
        test_random_traffic(6, 23, 23);
        test_random_traffic(7, 23, 23);

        wait_quiet();
        $display("covered %0d input items, %0d results, %0d register writes in %0d cycles",
                 items_sent, results_seen, reg_writes, cycle_count);
        $display("mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/lbps_pkg.sv
sv/lbps_front.sv
sv/lbps_back.sv
sv/lbps_out.sv
sv/leaky_bucket_packet_shaper.sv
bench/leaky_bucket_packet_shaper_tb.sv
